[rtl/core/dos_pkg.sv]
package dos_pkg;

    // Options area constants
    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
    localparam logic [7:0]  OPT_PAD      = 8'd0;
    localparam logic [7:0]  OPT_NETMASK  = 8'd1;
    localparam logic [7:0]  OPT_ROUTERS  = 8'd3;
    localparam logic [7:0]  OPT_END      = 8'd255;

    // Result status codes
    localparam logic [1:0] ST_END      = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // Register index (decoded from paddr[2])
    localparam logic REG_KEEP_NETMASK = 1'b0;
    localparam logic REG_KEEP_GATEWAY = 1'b1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_COOKIE = 6'b000010,
        PH_TAG    = 6'b000100,
        PH_LEN    = 6'b001000,
        PH_VALUE  = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // One scan result; status sits in the lowest bits
    typedef struct packed {
        logic        gateway_found;
        logic [31:0] gateway;
        logic        netmask_found;
        logic [31:0] netmask;
        logic [1:0]  status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[rtl/core/dhcp_option_scanner_top.sv]
// DHCP options scanner.
// Input stream: one byte of the BOOTP vendor options area per request.
//   s_tdata = data_byte, s_tuser = first_byte (restarts a scan at the cookie),
//   s_tlast = last_byte (no more data is available).
// Output stream: one request per finished scan, at the end tag, on a cookie
//   mismatch, or when the data ends before the end tag.
// Throughput: one input byte per cycle while s_tready is high. The parse state
//   updates at the edge where the byte is taken and the result is written into a
//   two-entry output queue at that same edge, so m_tvalid rises in the next cycle.
// Stall: bytes are still taken while a result waits; s_tready drops only
//   when both queue entries hold results not yet taken.
// APB: keep_netmask at 0x0, keep_gateway at 0x4; write only while idle.
// Reset: parser idle (bytes ignored until one carries first_byte), captures
//   and registers cleared, output queue empty.
module dhcp_option_scanner_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // data_byte[7:0]
    input  logic [dos_pkg::IN_TDATA_W-1:0]   s_tdata,
    // first_byte[0]
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // status[1:0], netmask[33:2], netmask_found[34], gateway[66:35],
    // gateway_found[67], zero[71:68]
    output logic [dos_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import dos_pkg::*;

    logic    keep_netmask_reg;
    logic    keep_gateway_reg;
    logic    cfg_write;
    logic    in_take;
    logic    res_valid;
    result_t res;

    result_t    q_mem [2];
    logic       q_wr_ptr_reg;
    logic       q_rd_ptr_reg;
    logic [1:0] q_count_reg, q_count_next;
    logic       q_push;
    logic       q_pop;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_netmask_reg <= 1'b0;
            keep_gateway_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_KEEP_NETMASK)
                keep_netmask_reg <= pwdata[0];
            else
                keep_gateway_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_KEEP_NETMASK)
            prdata = {31'd0, keep_netmask_reg};
        else
            prdata = {31'd0, keep_gateway_reg};
    end

    // Parser
    assign s_tready = (q_count_reg != 2'd2);
    assign in_take  = s_tvalid && s_tready;

    dos_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_take      (in_take),
        .data_byte    (s_tdata),
        .first_byte   (s_tuser),
        .last_byte    (s_tlast),
        .keep_netmask (keep_netmask_reg),
        .keep_gateway (keep_gateway_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Two-entry result queue
    assign q_push   = res_valid;
    assign q_pop    = m_tvalid && m_tready;
    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, q_mem[q_rd_ptr_reg]};

    always_comb
    begin
        q_count_next = q_count_reg;
        if (q_push && !q_pop)
            q_count_next = q_count_reg + 2'd1;
        else if (q_pop && !q_push)
            q_count_next = q_count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            if (q_pop)
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            q_count_reg <= q_count_next;
        end
    end

`ifndef SYNTHESIS
    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg != 2'd3)
        else $error("result queue count out of range");

    // A stalled input means the queue is full and the head is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && q_count_reg == 2'd2))
        else $error("input stalled without a full queue");

    // A cookie mismatch never carries captures
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == ST_MISMATCH) |-> (!m_tdata[34] && !m_tdata[67]))
        else $error("mismatch result with captured values");

    // Uncaptured router reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[67]) |-> (m_tdata[66:35] == 32'd0))
        else $error("gateway nonzero without capture");
`endif

endmodule

[rtl/core/dos_parse.sv]
module dos_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_take,
    input  logic [7:0]      data_byte,
    input  logic            first_byte,
    input  logic            last_byte,
    input  logic            keep_netmask,
    input  logic            keep_gateway,
    output logic            res_valid,
    output dos_pkg::result_t res
);
    import dos_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [23:0] cookie_shift_reg, cookie_shift_next;
    logic [1:0]  cookie_index_reg, cookie_index_next;
    logic [7:0]  option_code_reg, option_code_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  value_taken_reg, value_taken_next;
    logic [31:0] value_accum_reg, value_accum_next;
    logic [31:0] mask_held_reg, mask_held_next;
    logic        mask_valid_reg, mask_valid_next;
    logic [31:0] router_held_reg, router_held_next;
    logic        router_valid_reg, router_valid_next;

    logic        emit;
    logic [1:0]  emit_status;
    logic        scan_live;
    logic        finish;
    logic [31:0] full_cookie;
    logic [31:0] lane_byte;

    // Per-byte state update
    always_comb
    begin
        phase_next        = phase_reg;
        cookie_shift_next = cookie_shift_reg;
        cookie_index_next = cookie_index_reg;
        option_code_next  = option_code_reg;
        bytes_left_next   = bytes_left_reg;
        value_taken_next  = value_taken_reg;
        value_accum_next  = value_accum_reg;
        mask_held_next    = mask_held_reg;
        mask_valid_next   = mask_valid_reg;
        router_held_next  = router_held_reg;
        router_valid_next = router_valid_reg;
        emit              = 1'b0;
        emit_status       = ST_END;
        scan_live         = 1'b1;
        finish            = 1'b0;
        full_cookie       = {cookie_shift_reg, data_byte};
        lane_byte         = '0;

        // first_byte restarts the scan
        if (first_byte)
        begin
            phase_next        = PH_COOKIE;
            cookie_shift_next = '0;
            cookie_index_next = '0;
            option_code_next  = '0;
            bytes_left_next   = '0;
            value_taken_next  = '0;
            value_accum_next  = '0;
            mask_held_next    = '0;
            mask_valid_next   = 1'b0;
            router_held_next  = '0;
            router_valid_next = 1'b0;
            full_cookie       = {24'd0, data_byte};
        end

        case (phase_next)
            PH_COOKIE:
            begin
                if (cookie_index_next != 2'd3)
                begin
                    cookie_shift_next = {cookie_shift_next[15:0], data_byte};
                    cookie_index_next = cookie_index_next + 2'd1;
                end
                else
                begin
                    cookie_index_next = '0;
                    if (full_cookie != MAGIC_COOKIE)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_MISMATCH;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_TAG:
            begin
                if (data_byte == OPT_END)
                begin
                    emit        = 1'b1;
                    emit_status = ST_END;
                end
                else if (data_byte != OPT_PAD)
                begin
                    option_code_next = data_byte;
                    phase_next       = PH_LEN;
                end
            end
            PH_LEN:
            begin
                bytes_left_next  = data_byte;
                value_taken_next = '0;
                value_accum_next = '0;
                if (data_byte == 8'd0)
                    phase_next = PH_TAG;   // empty option: value zero, nothing captured
                else
                    phase_next = PH_VALUE;
            end
            PH_VALUE:
            begin
                // big-endian, left-aligned; bytes past the fourth are dropped
                if (!value_taken_next[2])
                begin
                    case (value_taken_next[1:0])
                        2'd0:    lane_byte = {data_byte, 24'd0};
                        2'd1:    lane_byte = {8'd0, data_byte, 16'd0};
                        2'd2:    lane_byte = {16'd0, data_byte, 8'd0};
                        default: lane_byte = {24'd0, data_byte};
                    endcase
                    value_accum_next = value_accum_next | lane_byte;
                    value_taken_next = value_taken_next + 3'd1;
                end
                bytes_left_next = bytes_left_next - 8'd1;
                finish          = (bytes_left_next == 8'd0);
            end
            default:
            begin
                scan_live = 1'b0;
            end
        endcase

        // Option complete: capture first nonzero mask / router unless its keep bit is set
        if (finish)
        begin
            phase_next = PH_TAG;
            if (value_accum_next != 32'd0)
            begin
                if (option_code_next == OPT_NETMASK && !keep_netmask && !mask_valid_next)
                begin
                    mask_held_next  = value_accum_next;
                    mask_valid_next = 1'b1;
                end
                else if (option_code_next == OPT_ROUTERS && !keep_gateway
                         && !router_valid_next)
                begin
                    router_held_next  = value_accum_next;
                    router_valid_next = 1'b1;
                end
            end
        end

        // Data ran out before the scan ended
        if (scan_live && !emit && last_byte)
        begin
            emit        = 1'b1;
            emit_status = ST_SHORT;
        end

        if (emit)
            phase_next = PH_DONE;
    end

    // Result taken from the updated captures
    always_comb
    begin
        res.status        = emit_status;
        res.netmask       = mask_valid_next ? mask_held_next : 32'd0;
        res.netmask_found = mask_valid_next;
        res.gateway       = router_valid_next ? router_held_next : 32'd0;
        res.gateway_found = router_valid_next;
    end

    assign res_valid = in_take && emit;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            cookie_shift_reg <= '0;
            cookie_index_reg <= '0;
            option_code_reg  <= '0;
            bytes_left_reg   <= '0;
            value_taken_reg  <= '0;
            value_accum_reg  <= '0;
            mask_held_reg    <= '0;
            mask_valid_reg   <= 1'b0;
            router_held_reg  <= '0;
            router_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg        <= phase_next;
            cookie_shift_reg <= cookie_shift_next;
            cookie_index_reg <= cookie_index_next;
            option_code_reg  <= option_code_next;
            bytes_left_reg   <= bytes_left_next;
            value_taken_reg  <= value_taken_next;
            value_accum_reg  <= value_accum_next;
            mask_held_reg    <= mask_held_next;
            mask_valid_reg   <= mask_valid_next;
            router_held_reg  <= router_held_next;
            router_valid_reg <= router_valid_next;
        end
    end

endmodule
